// ----- rtl/tss_pkg.sv -----
// Package for the three-stack shared-memory block.
// Holds sizes, operation and status codes. No dependencies.
package tss_pkg;

	localparam int unsigned MaxDepth  = 256;
	localparam int unsigned NumStacks = 3;
	localparam int unsigned MemDepth  = NumStacks * MaxDepth;
	localparam int unsigned AddrW     = $clog2(MemDepth);
	localparam int unsigned CapW      = 9;
	localparam int unsigned ValueW    = 32;

	localparam logic [CapW-1:0]   CapReset  = CapW'(MaxDepth);
	localparam logic [CapW-1:0]   CapMax    = CapW'(MaxDepth);
	localparam logic [1:0]        SelNone   = 2'd3;
	localparam logic [ValueW-1:0] NoneValue = '1;

	typedef enum logic [1:0] {
		OP_PUSH = 2'd0,
		OP_POP  = 2'd1,
		OP_PEEK = 2'd2
	} opcode_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_EMPTY   = 2'd1,
		ST_FULL    = 2'd2,
		ST_INVALID = 2'd3
	} status_t;

endpackage

// ----- rtl/tss_if.sv -----
// Valid/ready channel interfaces for requests and results of the stack block.
// Depends on tss_pkg for the field widths.
interface tss_req_if;
	import tss_pkg::*;
	logic                     valid;
	logic                     ready;
	logic [1:0]               opcode;
	logic [1:0]               stack_select;
	logic signed [ValueW-1:0] push_value;
	modport source (output valid, output opcode, output stack_select, output push_value,
		input ready);
	modport sink (input valid, input opcode, input stack_select, input push_value,
		output ready);
endinterface

interface tss_rsp_if;
	import tss_pkg::*;
	logic                     valid;
	logic                     ready;
	logic signed [ValueW-1:0] read_value;
	logic [1:0]               status;
	logic                     now_empty;
	modport source (output valid, output read_value, output status, output now_empty,
		input ready);
	modport sink (input valid, input read_value, input status, input now_empty,
		output ready);
endinterface

// ----- rtl/three_stacks_shared_memory.sv -----
// Three stacks sharing one 768-word memory. A result passes the registered stages
// s1 and s2 after its request transfer. Throughput: one request per cycle unless
// the result side stalls, set by the single memory port (one read or one write per
// request) and the fill counter update. Reset clears the three fill counters and
// sets the capacity register to 256. The entry memory is not cleared; the user must
// not read a word before it is pushed, which the block itself does not enforce.
module three_stacks_shared_memory (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [tss_pkg::CapW-1:0]  cfg_wdata,
	tss_req_if.sink                   req,
	tss_rsp_if.source                 rsp
);
	import tss_pkg::*;

	logic [CapW-1:0]   cap_q;
	logic [CapW-1:0]   fill_q [NumStacks];
	logic [ValueW-1:0] mem [MemDepth];
	logic [ValueW-1:0] rdata_q;

	logic              valid_s1;
	status_t           status_s1;
	logic              use_mem_s1;
	logic              empty_s1;

	logic              valid_s2;
	logic [ValueW-1:0] read_value_s2;
	status_t           status_s2;
	logic              empty_s2;

	logic              adv_s1;
	logic              accept;
	logic [CapW-1:0]   cap_eff;
	logic              sel_ok;
	logic [1:0]        sel;
	logic [CapW-1:0]   fill;
	logic [AddrW-1:0]  base;
	logic [AddrW-1:0]  addr;
	logic              mem_we;
	logic              mem_re;
	logic              fill_upd;
	logic [CapW-1:0]   fill_next;
	status_t           status_c;
	logic              empty_c;

	assign adv_s1    = !valid_s2 || rsp.ready;
	assign req.ready = !valid_s1 || adv_s1;
	assign accept    = req.valid && req.ready;

	assign cap_eff = (cap_q > CapMax) ? CapMax : cap_q;
	assign sel     = req.stack_select;
	assign sel_ok  = sel != SelNone;
	assign fill    = sel_ok ? fill_q[sel] : '0;

	always_comb begin
		case (sel)
			2'd1:    base = AddrW'(cap_eff);
			2'd2:    base = AddrW'({cap_eff, 1'b0});
			default: base = '0;
		endcase
	end

	always_comb begin
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		fill_upd  = 1'b0;
		fill_next = fill;
		addr      = base + AddrW'(fill);
		status_c  = ST_OK;
		if (!sel_ok) begin
			status_c = ST_INVALID;
		end else begin
			case (req.opcode)
				OP_PUSH: begin
					if (fill >= cap_eff) begin
						status_c = ST_FULL;
					end else begin
						mem_we    = 1'b1;
						fill_upd  = 1'b1;
						fill_next = fill + 1'b1;
					end
				end
				OP_POP, OP_PEEK: begin
					addr = base + AddrW'(fill) - 1'b1;
					if (fill == '0) begin
						status_c = ST_EMPTY;
					end else begin
						mem_re = 1'b1;
						if (req.opcode == OP_POP) begin
							fill_upd  = 1'b1;
							fill_next = fill - 1'b1;
						end
					end
				end
				default: status_c = ST_INVALID;
			endcase
		end
		empty_c = !sel_ok || (fill_next == '0);
	end

	always_ff @(posedge clk) begin
		if (accept && mem_we) begin
			mem[addr] <= req.push_value;
		end
		if (accept && mem_re) begin
			rdata_q <= mem[addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CapReset;
			for (int i = 0; i < NumStacks; i++) begin
				fill_q[i] <= '0;
			end
		end else begin
			if (cfg_we) begin
				cap_q <= cfg_wdata;
			end
			if (accept && fill_upd) begin
				fill_q[sel] <= fill_next;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (req.ready) begin
				valid_s1 <= accept;
			end
			if (adv_s1) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_s1  <= status_c;
			use_mem_s1 <= mem_re;
			empty_s1   <= empty_c;
		end
		if (adv_s1 && valid_s1) begin
			read_value_s2 <= use_mem_s1 ? rdata_q : NoneValue;
			status_s2     <= status_s1;
			empty_s2      <= empty_s1;
		end
	end

	assign rsp.valid      = valid_s2;
	assign rsp.read_value = read_value_s2;
	assign rsp.status     = status_s2;
	assign rsp.now_empty  = empty_s2;

endmodule

// ----- rtl/tss_checker.sv -----
// Port-level checks for the three-stack block and the bind that attaches them.
// Depends on tss_pkg and on the top level's port names.
module tss_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       req_valid,
	input logic                       req_ready,
	input logic                       rsp_valid,
	input logic                       rsp_ready,
	input logic [tss_pkg::ValueW-1:0] rsp_read_value,
	input logic [1:0]                 rsp_status,
	input logic                       rsp_now_empty
);
	import tss_pkg::*;

	logic [1:0] pending_q;
	logic       req_xfer;
	logic       rsp_xfer;

	assign req_xfer = req_valid && req_ready;
	assign rsp_xfer = rsp_valid && rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else begin
			pending_q <= pending_q + 2'(req_xfer) - 2'(rsp_xfer);
		end
	end

	// A result is only shown while a request is still owed one.
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> pending_q != 2'd0)
		else $error("result shown with no request outstanding");

	// At most two requests are in flight inside the block.
	a_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		(pending_q == 2'd2 && !rsp_xfer) |-> !req_ready)
		else $error("request taken with two results owed");

	a_err_value: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_status != ST_OK) |-> rsp_read_value == NoneValue)
		else $error("failed operation returned a value");

	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_status == ST_EMPTY) |-> rsp_now_empty)
		else $error("empty status without the empty flag");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |=> rsp_valid && $stable(rsp_read_value))
		else $error("stalled result changed");

endmodule

bind three_stacks_shared_memory tss_checker u_tss_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.req_valid      (req.valid),
	.req_ready      (req.ready),
	.rsp_valid      (rsp.valid),
	.rsp_ready      (rsp.ready),
	.rsp_read_value (rsp.read_value),
	.rsp_status     (rsp.status),
	.rsp_now_empty  (rsp.now_empty)
);

// ----- dv/tb_three_stacks_shared_memory.sv -----
// Testbench for three_stacks_shared_memory: directed and random stack operations with a
// local prediction of every result, random idling on both channels and capacity changes.
// Depends on tss_pkg, tss_req_if and tss_rsp_if from the RTL.
module tb_three_stacks_shared_memory;
	import tss_pkg::*;

	localparam logic [1:0] OpReserved   = 2'd3;
	localparam int         SettleCycles = 4;
	localparam int         QuietLimit   = 1000;
	localparam int         HoldCycles   = 48;

	typedef struct packed {
		logic signed [ValueW-1:0] read_value;
		status_t                  status;
		logic                     now_empty;
	} stack_result_t;

	logic            clk;
	logic            arst_n;
	logic            cfg_we;
	logic [CapW-1:0] cfg_wdata;

	tss_req_if req_ch ();
	tss_rsp_if rsp_ch ();

	three_stacks_shared_memory dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req_ch),
		.rsp       (rsp_ch)
	);

	logic signed [ValueW-1:0] model_mem [MemDepth];
	bit                       mem_written [MemDepth] = '{default: 1'b0};
	int unsigned              fill_count [NumStacks] = '{default: 0};
	logic [CapW-1:0]          capacity_reg = CapReset;
	stack_result_t            pending_results [$];

	int mismatches   = 0;
	int quiet_cycles = 0;
	bit idle_enable  = 1'b1;
	bit hold_pending = 1'b0;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic int unsigned effective_cap();
		return (capacity_reg > CapMax) ? MaxDepth : int'(capacity_reg);
	endfunction

	function automatic stack_result_t apply_stack_op(logic [1:0] op, logic [1:0] sel,
			logic signed [ValueW-1:0] val);
		stack_result_t r;
		int unsigned   cap;
		int unsigned   base;
		int unsigned   fill;
		int unsigned   addr;
		r.read_value = NoneValue;
		r.status     = ST_OK;
		r.now_empty  = 1'b1;
		if (sel == SelNone) begin
			r.status = ST_INVALID;
			return r;
		end
		cap  = effective_cap();
		base = sel * cap;
		fill = fill_count[sel];
		case (op)
			OP_PUSH: begin
				if (fill >= cap) begin
					r.status = ST_FULL;
				end else begin
					model_mem[base + fill]   = val;
					mem_written[base + fill] = 1'b1;
					fill_count[sel]          = fill + 1;
				end
			end
			OP_POP, OP_PEEK: begin
				if (fill == 0) begin
					r.status = ST_EMPTY;
				end else begin
					addr         = base + fill - 1;
					r.read_value = model_mem[addr];
					if (op == OP_POP)
						fill_count[sel] = fill - 1;
				end
			end
			default: r.status = ST_INVALID;
		endcase
		r.now_empty = (fill_count[sel] == 0);
		return r;
	endfunction

	always @(posedge clk) begin
		stack_result_t want;
		if (arst_n) begin
			if (cfg_we)
				capacity_reg = cfg_wdata;
			if (req_ch.valid && req_ch.ready)
				pending_results.push_back(apply_stack_op(req_ch.opcode, req_ch.stack_select,
					req_ch.push_value));
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (pending_results.size() == 0) begin
					$error("result transfer with no request outstanding");
					mismatches++;
				end else begin
					want = pending_results.pop_front();
					if (rsp_ch.read_value !== want.read_value) begin
						$error("read_value: expected %0d, got %0d", want.read_value,
							rsp_ch.read_value);
						mismatches++;
					end
					if (rsp_ch.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, rsp_ch.status);
						mismatches++;
					end
					if (rsp_ch.now_empty !== want.now_empty) begin
						$error("now_empty: expected %0d, got %0d", want.now_empty,
							rsp_ch.now_empty);
						mismatches++;
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || cfg_we)
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QuietLimit) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// The result side stalls at random, or holds off completely when a test asks for it.
	initial begin
		int hold_left;
		hold_left   = 0;
		rsp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_pending) begin
				hold_pending = 1'b0;
				hold_left    = HoldCycles;
			end
			if (hold_left > 0) begin
				rsp_ch.ready <= 1'b0;
				hold_left--;
			end else if (idle_enable) begin
				rsp_ch.ready <= ($urandom_range(99) >= 21);
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	task automatic send_op(input logic [1:0] op, input logic [1:0] sel,
			input logic signed [ValueW-1:0] val);
		while (idle_enable && $urandom_range(99) < 21) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid        <= 1'b1;
		req_ch.opcode       <= op;
		req_ch.stack_select <= sel;
		req_ch.push_value   <= val;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic send_random_op(input int unsigned push_pct);
		int unsigned              roll;
		int unsigned              addr;
		logic [1:0]               op;
		logic [1:0]               sel;
		logic signed [ValueW-1:0] val;
		roll = $urandom_range(99);
		if (roll < 4)
			op = OpReserved;
		else if (roll < 4 + push_pct)
			op = OP_PUSH;
		else if ($urandom_range(2) == 0)
			op = OP_PEEK;
		else
			op = OP_POP;
		sel = ($urandom_range(99) < 5) ? SelNone : 2'($urandom_range(NumStacks - 1));
		// A read of a word that was never pushed has no defined answer, so it becomes a push.
		if ((op == OP_POP || op == OP_PEEK) && sel != SelNone && fill_count[sel] != 0) begin
			addr = sel * effective_cap() + fill_count[sel] - 1;
			if (!mem_written[addr])
				op = OP_PUSH;
		end
		case ($urandom_range(9))
			0: val = '0;
			1: val = -1;
			2: val = 32'sh7FFF_FFFF;
			3: val = 32'sh8000_0000;
			default: val = $urandom;
		endcase
		send_op(op, sel, val);
	endtask

	task automatic drain_all();
		req_ch.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (SettleCycles) @(negedge clk);
	endtask

	task automatic set_capacity(input logic [CapW-1:0] value);
		drain_all();
		cfg_wdata <= value;
		cfg_we    <= 1'b1;
		@(negedge clk);
		cfg_we    <= 1'b0;
	endtask

	task automatic test_empty_and_invalid();
		send_op(OP_POP, 2'd0, '0);
		send_op(OP_PEEK, 2'd1, '0);
		send_op(OP_POP, 2'd2, '0);
		send_op(OP_PUSH, SelNone, 32'sh1234);
		send_op(OP_PEEK, SelNone, '0);
		send_op(OpReserved, 2'd0, '0);
		send_op(OpReserved, SelNone, -1);
		drain_all();
	endtask

	task automatic test_push_pop_extremes();
		set_capacity(CapW'(2));
		send_op(OP_PUSH, 2'd1, 32'sh7FFF_FFFF);
		send_op(OP_PUSH, 2'd1, 32'sh8000_0000);
		send_op(OP_PUSH, 2'd1, -1);
		send_op(OP_PEEK, 2'd1, '0);
		send_op(OP_POP, 2'd1, '0);
		send_op(OP_POP, 2'd1, '0);
		send_op(OP_POP, 2'd1, '0);
		send_op(OP_PUSH, 2'd2, '0);
		send_op(OpReserved, 2'd2, '0);
		drain_all();
	endtask

	// Stack 0 keeps its fill while the capacity shrinks below it and then to zero; 511 is clamped.
	task automatic test_capacity_change();
		set_capacity(CapW'(4));
		send_op(OP_PUSH, 2'd0, 32'sh0000_0011);
		send_op(OP_PUSH, 2'd0, 32'sh0000_0022);
		send_op(OP_PUSH, 2'd0, 32'sh0000_0033);
		send_op(OP_PUSH, 2'd0, 32'sh0000_0044);
		set_capacity(CapW'(2));
		send_op(OP_PUSH, 2'd0, 32'sh0000_0055);
		send_op(OP_POP, 2'd0, '0);
		set_capacity(CapW'(0));
		send_op(OP_PUSH, 2'd0, 32'sh0000_0066);
		send_op(OP_PEEK, 2'd0, '0);
		set_capacity(CapW'(511));
		send_op(OP_PUSH, 2'd1, 32'sh5A5A_A5A5);
		send_op(OP_POP, 2'd1, '0);
		drain_all();
	endtask

	task automatic test_output_backpressure();
		set_capacity(CapReset);
		hold_pending = 1'b1;
		repeat (60) send_random_op(60);
		drain_all();
	endtask

	task automatic test_random_traffic();
		int unsigned phase_caps [11] = '{256, 3, 1, 0, 17, 511, 8, 2, 255, 5, 64};
		foreach (phase_caps[i]) begin
			set_capacity(CapW'(phase_caps[i]));
			idle_enable = (i != 4);
			repeat (120) send_random_op((i % 2 == 0) ? 65 : 35);
		end
		idle_enable = 1'b1;
		drain_all();
	endtask

	initial begin
		arst_n              = 1'b0;
		cfg_we              = 1'b0;
		cfg_wdata           = '0;
		req_ch.valid        = 1'b0;
		req_ch.opcode       = '0;
		req_ch.stack_select = '0;
		req_ch.push_value   = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_empty_and_invalid();
		test_push_pop_extremes();
		test_capacity_change();
		test_output_backpressure();
		test_random_traffic();
		drain_all();

		if (mismatches == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/tss_pkg.sv
rtl/tss_if.sv
rtl/three_stacks_shared_memory.sv
rtl/tss_checker.sv
dv/tb_three_stacks_shared_memory.sv
